// File: rtl/bld_pkg.sv
`timescale 1ns / 1ps

package bld_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] REQ_APPEND    = 3'd0;
  localparam logic [2:0] REQ_PREPEND   = 3'd1;
  localparam logic [2:0] REQ_DEL_LAST  = 3'd2;
  localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [2:0] REQ_DEL_ALL   = 3'd4;
  localparam logic [2:0] REQ_DUMP      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_WR,
    S_HEAD,
    S_TRIM,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_APPEND,
    DP_DEC_CNT,
    DP_SET_CNT_WR,
    DP_HEAD,
    DP_INIT_PREP,
    DP_INIT_DELF,
    DP_INIT_SCAN,
    DP_READ,
    DP_MV_UP,
    DP_MV_DN,
    DP_FILTER,
    DP_EMIT,
    DP_FIN
  } dp_op_t;

  typedef struct packed {
    logic       load_req;
    dp_op_t     op;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       cnt_zero;
    logic       cnt_one;
    logic       cnt_full;
    logic       rd_ptr_zero;
    logic       rd_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: rtl/bounded_list_deque_engine.sv
`timescale 1ns / 1ps

// bounded ordered list of up to DEPTH words, driven by request items
// input channel: in_valid / in_stall with in_req_type and in_item_value;
//   an item is taken when in_valid is high and in_stall low
// result channel: out_valid / out_stall with status, entry total, entry word
//   and a last flag; every request gives one result, a dump one per entry
// the block works on one request at a time; in_stall is high from the
//   cycle after acceptance until the last result is in the output register
// append, delete last, unused codes, full or empty cases, prepend
//   onto an empty list and delete first of a single entry go from
//   decode straight to the final result; other prepends and delete
//   firsts read and write back each entry moved, then write the head
//   or trim the count; delete all reads each entry and packs the kept
//   ones; a dump reads and emits each entry, all through the single
//   registered read port of the entry store
// the output register lets a new request be taken while a result waits;
//   a stalled receiver holds the result and the walk waits on it
// reset (rst_n low, synchronous) empties the list and drops any result;
//   the entry store itself is not cleared, only counted entries are read

module bounded_list_deque_engine
  import bld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic [WORD_BITS-1:0] in_item_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_entry_total,
  output logic [WORD_BITS-1:0] out_entry_word,
  output logic                 out_last_result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bld_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_total (out_entry_total),
    .out_entry_word  (out_entry_word),
    .out_last_result (out_last_result)
  );

endmodule

// File: rtl/bld_ctrl.sv
`timescale 1ns / 1ps

module bld_ctrl
  import bld_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
        case (stat.req)
          REQ_APPEND: begin
            if (stat.cnt_full) st_nxt = ST_FULL;
          end
          REQ_PREPEND: begin
            if (stat.cnt_full) st_nxt = ST_FULL;
            else if (!stat.cnt_zero) state_nxt = S_RD;
          end
          REQ_DEL_LAST: begin
            if (stat.cnt_zero) st_nxt = ST_EMPTY;
          end
          REQ_DEL_FIRST: begin
            if (stat.cnt_zero) st_nxt = ST_EMPTY;
            else if (!stat.cnt_one) state_nxt = S_RD;
          end
          REQ_DEL_ALL, REQ_DUMP: begin
            if (stat.cnt_zero) st_nxt = ST_EMPTY;
            else state_nxt = S_RD;
          end
          default: ;
        endcase
      end
      S_RD: state_nxt = S_WR;
      S_WR: begin
        case (stat.req)
          REQ_PREPEND: state_nxt = stat.rd_ptr_zero ? S_HEAD : S_RD;
          REQ_DEL_FIRST, REQ_DEL_ALL: state_nxt = stat.rd_last ? S_TRIM : S_RD;
          REQ_DUMP: begin
            if (stat.out_free) state_nxt = stat.rd_last ? S_IDLE : S_RD;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_HEAD: state_nxt = S_FIN;
      S_TRIM: state_nxt = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.load_req = 1'b0;
    cmd.op       = DP_NONE;
    cmd.st       = st_r;
    in_stall     = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd.load_req = in_valid;
      S_DEC: begin
        case (stat.req)
          REQ_APPEND: begin
            if (!stat.cnt_full) cmd.op = DP_APPEND;
          end
          REQ_PREPEND: begin
            if (!stat.cnt_full) cmd.op = stat.cnt_zero ? DP_HEAD : DP_INIT_PREP;
          end
          REQ_DEL_LAST: begin
            if (!stat.cnt_zero) cmd.op = DP_DEC_CNT;
          end
          REQ_DEL_FIRST: begin
            if (!stat.cnt_zero) cmd.op = stat.cnt_one ? DP_DEC_CNT : DP_INIT_DELF;
          end
          REQ_DEL_ALL, REQ_DUMP: begin
            if (!stat.cnt_zero) cmd.op = DP_INIT_SCAN;
          end
          default: ;
        endcase
      end
      S_RD: cmd.op = DP_READ;
      S_WR: begin
        case (stat.req)
          REQ_PREPEND:   cmd.op = DP_MV_UP;
          REQ_DEL_FIRST: cmd.op = DP_MV_DN;
          REQ_DEL_ALL:   cmd.op = DP_FILTER;
          REQ_DUMP: begin
            if (stat.out_free) cmd.op = DP_EMIT;
          end
          default: ;
        endcase
      end
      S_HEAD: cmd.op = DP_HEAD;
      S_TRIM: cmd.op = (stat.req == REQ_DEL_ALL) ? DP_SET_CNT_WR : DP_DEC_CNT;
      S_FIN: begin
        if (stat.out_free) cmd.op = DP_FIN;
      end
      default: ;
    endcase
  end

  // a new item is taken only from idle, and work starts the cycle after
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DEC))
    else $error("accepted item not decoded");

  // a dump of a non-empty list leaves through the walk, never through the final-result state
  a_dump_no_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && stat.req == REQ_DUMP) |-> (st_r == ST_EMPTY))
    else $error("dump of a non-empty list reached final state");

  a_head_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD) |-> !stat.cnt_full)
    else $error("prepend head write on a full list");

endmodule

// File: rtl/bld_datapath.sv
`timescale 1ns / 1ps

module bld_datapath
  import bld_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [2:0]           in_req_type,
  input  logic [WORD_BITS-1:0] in_item_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [CNT_W-1:0]     out_entry_total,
  output logic [WORD_BITS-1:0] out_entry_word,
  output logic                 out_last_result
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [2:0]           req_r;
  logic [WORD_BITS-1:0] val_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     wr_ptr_r, wr_ptr_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [CNT_W-1:0]     out_total_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic                 out_last_r;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [CNT_W-1:0]     rd_ptr_ext;
  logic                 out_free;
  logic                 out_load;

  assign rd_ptr_ext = CNT_W'(rd_ptr_r);
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = (cmd.op == DP_EMIT) || (cmd.op == DP_FIN);

  assign stat.req         = req_r;
  assign stat.cnt_zero    = (cnt_r == '0);
  assign stat.cnt_one     = (cnt_r == CNT_W'(1));
  assign stat.cnt_full    = (cnt_r >= CNT_W'(DEPTH));
  assign stat.rd_ptr_zero = (rd_ptr_r == '0);
  assign stat.rd_last     = (rd_ptr_ext + CNT_W'(1) == cnt_r);
  assign stat.out_free    = out_free;

  always_comb begin
    cnt_nxt    = cnt_r;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    wr_en      = 1'b0;
    wr_addr    = cnt_r[IDX_W-1:0];
    wr_data    = val_r;
    case (cmd.op)
      DP_APPEND: begin
        wr_en   = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      DP_DEC_CNT:    cnt_nxt = cnt_r - CNT_W'(1);
      DP_SET_CNT_WR: cnt_nxt = wr_ptr_r;
      DP_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      DP_INIT_PREP: rd_ptr_nxt = IDX_W'(cnt_r - CNT_W'(1));
      DP_INIT_DELF: rd_ptr_nxt = IDX_W'(1);
      DP_INIT_SCAN: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
      end
      DP_MV_UP: begin
        wr_en      = 1'b1;
        wr_addr    = rd_ptr_r + IDX_W'(1);
        wr_data    = rd_data_r;
        rd_ptr_nxt = rd_ptr_r - IDX_W'(1);
      end
      DP_MV_DN: begin
        wr_en      = 1'b1;
        wr_addr    = rd_ptr_r - IDX_W'(1);
        wr_data    = rd_data_r;
        rd_ptr_nxt = rd_ptr_r + IDX_W'(1);
      end
      DP_FILTER: begin
        // keep entries that differ from the match word, packed from the front
        if (rd_data_r != val_r) begin
          wr_en      = 1'b1;
          wr_addr    = wr_ptr_r[IDX_W-1:0];
          wr_data    = rd_data_r;
          wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
        end
        rd_ptr_nxt = rd_ptr_r + IDX_W'(1);
      end
      DP_EMIT: rd_ptr_nxt = rd_ptr_r + IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.op == DP_READ) rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
    end
    rd_ptr_r <= rd_ptr_nxt;
    wr_ptr_r <= wr_ptr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r <= cnt_r;
      if (cmd.op == DP_EMIT) begin
        out_status_r <= ST_OK;
        out_word_r   <= rd_data_r;
        out_last_r   <= stat.rd_last;
      end else begin
        out_status_r <= cmd.st;
        out_word_r   <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_total_r;
  assign out_entry_word  = out_word_r;
  assign out_last_result = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten while held");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_APPEND) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("append did not grow the list");

endmodule
